>>> hdl/bgwmb_pkg.sv
// shared types, constants and register indexes for the bayer grid mean brightness block
`timescale 1ns / 1ps

package bgwmb_pkg;

  // field and register widths
  localparam int PIX_W    = 8;
  localparam int POS_W    = 12;
  localparam int STRIDE_W = 13;
  localparam int BLK_W    = 9;
  localparam int WGT_W    = 16;
  localparam int WSET_W   = 48;
  localparam int PROD_W   = PIX_W + WGT_W;
  localparam int SUM_W    = 42;
  localparam int CNT_W    = 2 * BLK_W - 1;
  localparam int MEAN_W   = 26;
  localparam int IDX_W    = 3;
  localparam int DATA_W   = WSET_W;
  localparam int STEP_W   = 6;

  // limits of the sampling grid
  localparam logic [POS_W-1:0]    POS_LAST   = {POS_W{1'b1}};
  localparam logic [STRIDE_W-1:0] STRIDE_MIN = STRIDE_W'(2);
  localparam logic [STRIDE_W-1:0] STRIDE_MAX = STRIDE_W'(4096);
  localparam logic [BLK_W-1:0]    BLOCKS_MAX = BLK_W'(256);

  // divider length
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);

  // register indexes
  localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_STRIDE_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_STRIDE_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_BLOCKS_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_BLOCKS_Y = 3'd5;
  localparam logic [IDX_W-1:0] REG_WEIGHTS  = 3'd6;

  // register reset values
  localparam logic [WSET_W-1:0] WEIGHTS_RESET = 48'h1323_12C9_074C;

  // one finished frame waiting for its division
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } frame_job_t;

endpackage

>>> hdl/bgwmb_ifs.sv
// valid/ready channel interfaces for pixel words and result words
`timescale 1ns / 1ps

interface bgwmb_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [bgwmb_pkg::PIX_W-1:0]  pixel;
  logic                         line_end;
  logic                         frame_end;

  modport source (output valid, pixel, line_end, frame_end, input ready);
  modport sink (input valid, pixel, line_end, frame_end, output ready);
endinterface

interface bgwmb_mean_if;
  logic                         valid;
  logic                         ready;
  logic [bgwmb_pkg::MEAN_W-1:0] mean_brightness;

  modport source (output valid, mean_brightness, input ready);
  modport sink (input valid, mean_brightness, output ready);
endinterface

>>> hdl/bgwmb_front.sv
// front end: config registers, position counters, grid sampling and accumulation
`timescale 1ns / 1ps

module bgwmb_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [bgwmb_pkg::IDX_W-1:0]    wr_index,
  input  logic [bgwmb_pkg::DATA_W-1:0]   wr_data,
  bgwmb_pixel_if.sink                    pix_in,
  output logic                           job_valid,
  input  logic                           job_ready,
  output bgwmb_pkg::frame_job_t          job
);

  // configuration registers
  logic [bgwmb_pkg::POS_W-1:0]    origin_x;
  logic [bgwmb_pkg::POS_W-1:0]    origin_y;
  logic [bgwmb_pkg::STRIDE_W-1:0] stride_x;
  logic [bgwmb_pkg::STRIDE_W-1:0] stride_y;
  logic [bgwmb_pkg::BLK_W-1:0]    blocks_x;
  logic [bgwmb_pkg::BLK_W-1:0]    blocks_y;
  logic [bgwmb_pkg::WSET_W-1:0]   channel_weights;

  // frame state
  logic [bgwmb_pkg::POS_W-1:0]    column;
  logic [bgwmb_pkg::POS_W-1:0]    row;
  logic [bgwmb_pkg::POS_W-1:0]    column_phase;
  logic [bgwmb_pkg::BLK_W-1:0]    block_column;
  logic [bgwmb_pkg::POS_W-1:0]    row_phase;
  logic [bgwmb_pkg::BLK_W-1:0]    block_row;
  logic [bgwmb_pkg::SUM_W-1:0]    weighted_sum;

  logic [bgwmb_pkg::STRIDE_W-1:0] sx, sy;
  logic [bgwmb_pkg::BLK_W-1:0]    bx, by;
  logic                           x_live, y_live, sample_hit;
  logic [bgwmb_pkg::WGT_W-1:0]    weight;
  logic [bgwmb_pkg::PROD_W-1:0]   product;
  logic [bgwmb_pkg::SUM_W-1:0]    sum_next;
  logic [bgwmb_pkg::STRIDE_W-1:0] cphase_inc, rphase_inc;
  logic                           accept, row_close;

  // clamped stride and block count
  always_comb begin
    sx = stride_x;
    if (stride_x < bgwmb_pkg::STRIDE_MIN) sx = bgwmb_pkg::STRIDE_MIN;
    else if (stride_x > bgwmb_pkg::STRIDE_MAX) sx = bgwmb_pkg::STRIDE_MAX;
    sy = stride_y;
    if (stride_y < bgwmb_pkg::STRIDE_MIN) sy = bgwmb_pkg::STRIDE_MIN;
    else if (stride_y > bgwmb_pkg::STRIDE_MAX) sy = bgwmb_pkg::STRIDE_MAX;
    bx = (blocks_x > bgwmb_pkg::BLOCKS_MAX) ? bgwmb_pkg::BLOCKS_MAX : blocks_x;
    by = (blocks_y > bgwmb_pkg::BLOCKS_MAX) ? bgwmb_pkg::BLOCKS_MAX : blocks_y;
  end

  // grid membership and channel weight
  always_comb begin
    x_live = (column >= origin_x) && (block_column < bx);
    y_live = (row >= origin_y) && (block_row < by);
    sample_hit = x_live && y_live && (column_phase < bgwmb_pkg::POS_W'(2))
                 && (row_phase < bgwmb_pkg::POS_W'(2));
    if (!column_phase[0] && !row_phase[0]) begin
      weight = channel_weights[15:0];
    end else if (column_phase[0] && row_phase[0]) begin
      weight = channel_weights[47:32];
    end else begin
      weight = channel_weights[31:16];
    end
    product = bgwmb_pkg::PROD_W'(pix_in.pixel) * weight;
    sum_next = sample_hit ? weighted_sum + bgwmb_pkg::SUM_W'(product) : weighted_sum;
    cphase_inc = bgwmb_pkg::STRIDE_W'(column_phase) + bgwmb_pkg::STRIDE_W'(1);
    rphase_inc = bgwmb_pkg::STRIDE_W'(row_phase) + bgwmb_pkg::STRIDE_W'(1);
  end

  // handshake: a frame end needs room in the queue, so stall on a full queue
  assign pix_in.ready = job_ready;
  assign accept       = pix_in.valid && pix_in.ready;
  assign row_close    = pix_in.line_end || pix_in.frame_end;
  assign job_valid    = accept && pix_in.frame_end;
  assign job.sum      = sum_next;
  assign job.count    = bgwmb_pkg::CNT_W'(bx) * bgwmb_pkg::CNT_W'(by);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x        <= '0;
      origin_y        <= '0;
      stride_x        <= bgwmb_pkg::STRIDE_MIN;
      stride_y        <= bgwmb_pkg::STRIDE_MIN;
      blocks_x        <= bgwmb_pkg::BLK_W'(1);
      blocks_y        <= bgwmb_pkg::BLK_W'(1);
      channel_weights <= bgwmb_pkg::WEIGHTS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        bgwmb_pkg::REG_ORIGIN_X: origin_x <= wr_data[bgwmb_pkg::POS_W-1:0];
        bgwmb_pkg::REG_ORIGIN_Y: origin_y <= wr_data[bgwmb_pkg::POS_W-1:0];
        bgwmb_pkg::REG_STRIDE_X: stride_x <= wr_data[bgwmb_pkg::STRIDE_W-1:0];
        bgwmb_pkg::REG_STRIDE_Y: stride_y <= wr_data[bgwmb_pkg::STRIDE_W-1:0];
        bgwmb_pkg::REG_BLOCKS_X: blocks_x <= wr_data[bgwmb_pkg::BLK_W-1:0];
        bgwmb_pkg::REG_BLOCKS_Y: blocks_y <= wr_data[bgwmb_pkg::BLK_W-1:0];
        bgwmb_pkg::REG_WEIGHTS:  channel_weights <= wr_data[bgwmb_pkg::WSET_W-1:0];
        default: ;
      endcase
    end
  end

  // counters and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      row          <= '0;
      column_phase <= '0;
      block_column <= '0;
      row_phase    <= '0;
      block_row    <= '0;
      weighted_sum <= '0;
    end else if (accept) begin
      // frame end clears everything once the job is handed over
      if (pix_in.frame_end) begin
        column       <= '0;
        row          <= '0;
        column_phase <= '0;
        block_column <= '0;
        row_phase    <= '0;
        block_row    <= '0;
        weighted_sum <= '0;
      end else begin
        weighted_sum <= sum_next;
        if (row_close) begin
          column       <= '0;
          column_phase <= '0;
          block_column <= '0;
          if (y_live) begin
            if (rphase_inc >= sy) begin
              row_phase <= '0;
              block_row <= block_row + bgwmb_pkg::BLK_W'(1);
            end else begin
              row_phase <= rphase_inc[bgwmb_pkg::POS_W-1:0];
            end
          end
          if (row != bgwmb_pkg::POS_LAST) row <= row + bgwmb_pkg::POS_W'(1);
        end else begin
          if (x_live) begin
            if (cphase_inc >= sx) begin
              column_phase <= '0;
              block_column <= block_column + bgwmb_pkg::BLK_W'(1);
            end else begin
              column_phase <= cphase_inc[bgwmb_pkg::POS_W-1:0];
            end
          end
          if (column != bgwmb_pkg::POS_LAST) column <= column + bgwmb_pkg::POS_W'(1);
        end
      end
    end
  end

endmodule

>>> hdl/bgwmb_queue.sv
// two-entry queue of finished frame sums between front end and divider
`timescale 1ns / 1ps

module bgwmb_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  bgwmb_pkg::frame_job_t push_job,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output bgwmb_pkg::frame_job_t pop_job
);

  bgwmb_pkg::frame_job_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       do_push, do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) fill <= fill + 2'd1;
      else if (do_pop && !do_push) fill <= fill - 2'd1;
    end
  end

endmodule

>>> hdl/bgwmb_div.sv
// back end: bit-serial restoring divider of frame sum by block count, with output register
`timescale 1ns / 1ps

module bgwmb_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  bgwmb_pkg::frame_job_t job,
  bgwmb_mean_if.source          mean_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                    state;
  logic [bgwmb_pkg::STEP_W-1:0]  step;
  logic [bgwmb_pkg::SUM_W-1:0]   quo;
  logic [bgwmb_pkg::CNT_W-1:0]   rem;
  logic [bgwmb_pkg::CNT_W-1:0]   divisor;
  logic                          zero_div;
  logic                          out_valid;
  logic [bgwmb_pkg::MEAN_W-1:0]  out_data;

  logic [bgwmb_pkg::CNT_W:0]     shifted, diff;
  logic                          fits;
  logic                          out_free;

  // one quotient bit per cycle
  always_comb begin
    shifted = {rem, quo[bgwmb_pkg::SUM_W-1]};
    fits    = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  assign out_free  = !out_valid || mean_out.ready;
  assign job_ready = (state == ST_IDLE);
  assign mean_out.valid = out_valid;
  assign mean_out.mean_brightness = out_data;

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_data <= zero_div ? '0 : quo[bgwmb_pkg::MEAN_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) out_valid <= 1'b1;
      else if (mean_out.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            state <= ST_DIV;
            step  <= '0;
          end
        end
        ST_DIV: begin
          step <= step + bgwmb_pkg::STEP_W'(1);
          if (step == bgwmb_pkg::DIV_LAST) state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && job_valid) begin
      quo      <= job.sum;
      rem      <= '0;
      divisor  <= job.count;
      zero_div <= (job.count == '0);
    end else if (state == ST_DIV) begin
      rem <= fits ? diff[bgwmb_pkg::CNT_W-1:0] : shifted[bgwmb_pkg::CNT_W-1:0];
      quo <= {quo[bgwmb_pkg::SUM_W-2:0], fits};
    end
  end

endmodule

>>> hdl/bayer_grid_weighted_mean_brightness_core.sv
// Top level of the bayer grid weighted mean brightness block.
// Throughput: one pixel word per cycle; the front end stalls only when two frame results
// are already queued for the divider.
// A frame's result passes through the queue, the 42-step bit-serial divider and the output
// register; the divider takes no new frame sum until the current division is finished.
// Reset (synchronous, rst high) restores all config registers to their reset values and clears the
// position counters, accumulator and queue, and clears the output valid flag.
`timescale 1ns / 1ps

module bayer_grid_weighted_mean_brightness_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [bgwmb_pkg::IDX_W-1:0]  wr_index,
  input  logic [bgwmb_pkg::DATA_W-1:0] wr_data,
  bgwmb_pixel_if.sink                  pix_in,
  bgwmb_mean_if.source                 mean_out
);

  logic                  push_valid, push_ready;
  bgwmb_pkg::frame_job_t push_job;
  logic                  pop_valid, pop_ready;
  bgwmb_pkg::frame_job_t pop_job;

  // pixel side
  bgwmb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .pix_in    (pix_in),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_job)
  );

  // frame sums waiting for division
  bgwmb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // division and result word
  bgwmb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .mean_out  (mean_out)
  );

endmodule
